### hw/rtl/shbs_pkg.sv
// Shared types and constants for the SHA-256 byte stream hasher.
// Holds the item payload structs, the round constants and the initial hash.
// No dependencies.
package shbs_pkg;

	// One message item: a byte, its presence flag and the end-of-message flag
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       message_end;
	} shbs_msg_t;

	// One digest item: a word of the final hash and its position
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} shbs_digest_t;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned HASH_WDS  = 8;
	localparam int unsigned BLK_WDS   = 16;
	localparam int unsigned ROUNDS    = 64;

	// Byte positions inside a 64-byte block, the last round and the last digest word index
	localparam logic [5:0] FILL_LAST      = 6'd63;
	localparam logic [5:0] FILL_LEN_START = 6'd56;
	localparam logic [5:0] ROUND_LAST     = 6'd63;
	localparam logic [2:0] WORD_LAST      = 3'd7;

	localparam logic [7:0] PAD_MARK = 8'h80;

	// Initial hash, word 0 is the most significant
	localparam logic [WORD_W-1:0] SHBS_IV [HASH_WDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// Round constants
	localparam logic [WORD_W-1:0] SHBS_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

### hw/rtl/shbs_msg_if.sv
// Valid/ready channel carrying message items into the hasher.
// Depends on shbs_pkg for the payload type.
interface shbs_msg_if
	import shbs_pkg::*;
	;
	logic      valid;
	logic      ready;
	shbs_msg_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/shbs_digest_if.sv
// Valid/ready channel carrying digest words out of the hasher.
// Depends on shbs_pkg for the payload type.
interface shbs_digest_if
	import shbs_pkg::*;
	;
	logic         valid;
	logic         ready;
	shbs_digest_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/sha256_byte_stream_hasher.sv
// SHA-256 over a byte stream, one shared round unit under a small sequencer.
// Depends on shbs_pkg, shbs_msg_if and shbs_digest_if.
//
// Usage:
//   msg carries one item per handshake: a byte with its presence flag and an
//   end-of-message flag. msg.ready is high only while the block is idle.
//   The byte that completes a 64-byte block starts a compression: 64 rounds
//   and then a fold of the result into the chain value, during which
//   msg.ready is low. On message end the sequencer pushes the padding one
//   byte per cycle outside compressions (0x80, zeros, then the 8 length
//   bytes) through the same byte path, so finalization ends in one
//   compression, or two when the padding spills into an extra block. The
//   single round unit sets the sustained rate (64 rounds per 64 bytes); no
//   new byte is taken while a compression runs.
//   digest then presents eight words, index 0 first, last_word on index 7.
//   digest.valid holds each word until digest.ready; a stalled receiver
//   simply holds the block in that state. After the eighth word the block
//   clears its length and fill and reloads the initial hash.
//   Reset (arst_n low) loads the initial hash, clears fill and length and
//   returns to idle; no clearing pass is needed.
module sha256_byte_stream_hasher
	import shbs_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	shbs_msg_if.sink        msg,
	shbs_digest_if.source   digest
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAD   = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_FOLD  = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0]  state_q;
	logic [5:0]  fill_q;
	logic [63:0] len_q;
	logic        pad_q;
	logic        pad_first_q;
	logic        len_phase_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;

	logic [WORD_W-1:0] chain_q [HASH_WDS];
	logic [WORD_W-1:0] work_q [HASH_WDS];
	// Message window, word 15 is the oldest (current round) word
	logic [BLK_WDS-1:0][WORD_W-1:0] win_q;

	logic        msg_acc;
	logic        push_en;
	logic        push_full;
	logic        len_phase_n;
	logic [7:0]  push_byte;

	logic [WORD_W-1:0] w_new;
	logic [WORD_W-1:0] t1;
	logic [WORD_W-1:0] t2;

	function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (WORD_W - n));
	endfunction

	// Handshakes
	assign msg.ready    = (state_q == ST_IDLE);
	assign msg_acc      = msg.valid && msg.ready;
	assign digest.valid = (state_q == ST_EMIT);
	assign digest.data.digest_word = chain_q[idx_q];
	assign digest.data.word_index  = idx_q;
	assign digest.data.last_word   = (idx_q == WORD_LAST);

	// Byte path: message bytes while idle, padding bytes while padding
	assign len_phase_n = len_phase_q || (!pad_first_q && (fill_q == FILL_LEN_START));
	assign push_full   = (fill_q == FILL_LAST);

	always_comb begin
		push_en   = 1'b0;
		push_byte = msg.data.data_byte;
		unique case (state_q)
			ST_IDLE: begin
				push_en = msg_acc && msg.data.byte_present;
			end
			ST_PAD: begin
				push_en = 1'b1;
				if (pad_first_q) begin
					push_byte = PAD_MARK;
				end else if (len_phase_n) begin
					push_byte = len_q[63:56];
				end else begin
					push_byte = 8'h00;
				end
			end
			default: begin
				push_en = 1'b0;
			end
		endcase
	end

	// Round unit and schedule expansion
	always_comb begin
		w_new = (rotr(win_q[1], 17) ^ rotr(win_q[1], 19) ^ (win_q[1] >> 10))
			+ win_q[6]
			+ (rotr(win_q[14], 7) ^ rotr(win_q[14], 18) ^ (win_q[14] >> 3))
			+ win_q[15];
		t1 = work_q[7]
			+ (rotr(work_q[4], 6) ^ rotr(work_q[4], 11) ^ rotr(work_q[4], 25))
			+ ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
			+ SHBS_K[rnd_q]
			+ win_q[15];
		t2 = (rotr(work_q[0], 2) ^ rotr(work_q[0], 13) ^ rotr(work_q[0], 22))
			+ ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2])
			^ (work_q[1] & work_q[2]));
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (push_en) begin
			win_q <= (BLK_WDS*WORD_W)'({win_q, push_byte});
		end else if (state_q == ST_ROUND) begin
			win_q <= {win_q[BLK_WDS-2:0], w_new};
		end
		if (push_en && push_full) begin
			work_q <= chain_q;
		end else if (state_q == ST_ROUND) begin
			work_q[0] <= t1 + t2;
			work_q[1] <= work_q[0];
			work_q[2] <= work_q[1];
			work_q[3] <= work_q[2];
			work_q[4] <= work_q[3] + t1;
			work_q[5] <= work_q[4];
			work_q[6] <= work_q[5];
			work_q[7] <= work_q[6];
		end
	end

	// Sequencer and message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			len_q       <= '0;
			pad_q       <= 1'b0;
			pad_first_q <= 1'b0;
			len_phase_q <= 1'b0;
			rnd_q       <= '0;
			idx_q       <= '0;
			for (int i = 0; i < HASH_WDS; i++) begin
				chain_q[i] <= SHBS_IV[i];
			end
		end else begin
			if (push_en) begin
				fill_q <= fill_q + 6'd1;
				if (push_full) begin
					rnd_q <= '0;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (msg_acc) begin
						if (msg.data.byte_present) begin
							len_q <= len_q + 64'd8;
						end
						if (msg.data.message_end) begin
							pad_q       <= 1'b1;
							pad_first_q <= 1'b1;
						end
						if (push_en && push_full) begin
							state_q <= ST_ROUND;
						end else if (msg.data.message_end) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pad_first_q <= 1'b0;
					len_phase_q <= len_phase_n;
					if (len_phase_n) begin
						len_q <= {len_q[55:0], 8'h00};
					end
					if (push_full) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == ROUND_LAST) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					for (int i = 0; i < HASH_WDS; i++) begin
						chain_q[i] <= chain_q[i] + work_q[i];
					end
					// Final block done when the length bytes went in
					if (len_phase_q) begin
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end else if (pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (digest.ready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == WORD_LAST) begin
							state_q     <= ST_IDLE;
							fill_q      <= '0;
							len_q       <= '0;
							pad_q       <= 1'b0;
							pad_first_q <= 1'b0;
							len_phase_q <= 1'b0;
							for (int i = 0; i < HASH_WDS; i++) begin
								chain_q[i] <= SHBS_IV[i];
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
